// ----- design/dmra_pkg.sv -----
`timescale 1ns / 1ps
package dmra_pkg;

  localparam int RES_BITS = 30;
  localparam int EXP_BITS = 63;
  localparam int INT_BITS = 64;
  localparam int CNT_BITS = 7;
  localparam int IT_BITS  = 6;

  localparam logic [RES_BITS-1:0] MOD0_RESET = 30'd1000000007;
  localparam logic [RES_BITS-1:0] MOD1_RESET = 30'd1000000009;
  localparam logic [RES_BITS-1:0] MOD_MIN    = 30'd2;

  // operation codes
  localparam logic [2:0] K_CONV = 3'd0;
  localparam logic [2:0] K_ADD  = 3'd1;
  localparam logic [2:0] K_SUB  = 3'd2;
  localparam logic [2:0] K_MUL  = 3'd3;
  localparam logic [2:0] K_POW  = 3'd4;
  localparam logic [2:0] K_INV  = 3'd5;
  localparam logic [2:0] K_LT   = 3'd6;
  localparam logic [2:0] K_EQ   = 3'd7;

  // datapath phases: pick operand sources on start and destination on writeback
  localparam logic [2:0] PH_RA   = 3'd0;  // reduce a
  localparam logic [2:0] PH_RB   = 3'd1;  // reduce b
  localparam logic [2:0] PH_CONV = 3'd2;  // reduce integer magnitude
  localparam logic [2:0] PH_MUL  = 3'd3;  // a * b
  localparam logic [2:0] PH_SQ   = 3'd4;  // p * p
  localparam logic [2:0] PH_ML   = 3'd5;  // p * a, kept when exponent bit set

  localparam logic [0:0] REG_MOD0 = 1'b0;

  typedef struct packed {
    logic       capture;
    logic       start;
    logic       step;
    logic       wb;
    logic [2:0] ph;
    logic [2:0] kind;
  } lane_cmd_t;

endpackage

// ----- design/dmra_lane.sv -----
`timescale 1ns / 1ps
module dmra_lane import dmra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_cmd_t           cmd_i,
  input  logic [RES_BITS-1:0] mod_i,
  input  logic [RES_BITS-1:0] a_i,
  input  logic [RES_BITS-1:0] b_i,
  input  logic [INT_BITS-1:0] int_i,
  input  logic [EXP_BITS-1:0] exp_i,
  output logic [RES_BITS-1:0] res_o,
  output logic                lt_o,
  output logic                eq_o
);

  localparam int PAD = INT_BITS - RES_BITS;
  localparam int EPAD = EXP_BITS - RES_BITS;

  logic [RES_BITS-1:0] a_q, b_q, p_q, mc_q, acc_q;
  logic [RES_BITS-1:0] mc_d, acc_d, conv_r;
  logic [INT_BITS-1:0] sh_q, mag_q, sh_d;
  logic [EXP_BITS-1:0] e_q;
  logic                neg_q;
  logic [RES_BITS:0]   t, t2, u, u2, s, s2;

  // interleaved modular multiply: acc = 2*acc + bit*mc (mod m), msb first
  always_comb begin
    t  = {acc_q, 1'b0};
    t2 = (t >= {1'b0, mod_i}) ? t - {1'b0, mod_i} : t;
    u  = t2 + (sh_q[INT_BITS-1] ? {1'b0, mc_q} : '0);
    u2 = (u >= {1'b0, mod_i}) ? u - {1'b0, mod_i} : u;
    acc_d = u2[RES_BITS-1:0];
  end

  always_comb begin
    sh_d = {a_q, {PAD{1'b0}}};
    mc_d = RES_BITS'(1);
    case (cmd_i.ph)
      PH_RA:   begin sh_d = {a_q, {PAD{1'b0}}}; mc_d = RES_BITS'(1); end
      PH_RB:   begin sh_d = {b_q, {PAD{1'b0}}}; mc_d = RES_BITS'(1); end
      PH_CONV: begin sh_d = mag_q; mc_d = RES_BITS'(1); end
      PH_MUL:  begin sh_d = {b_q, {PAD{1'b0}}}; mc_d = a_q; end
      PH_SQ:   begin sh_d = {p_q, {PAD{1'b0}}}; mc_d = p_q; end
      PH_ML:   begin sh_d = {p_q, {PAD{1'b0}}}; mc_d = a_q; end
      default: begin sh_d = {a_q, {PAD{1'b0}}}; mc_d = RES_BITS'(1); end
    endcase
  end

  assign conv_r = (neg_q && acc_q != '0) ? mod_i - acc_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q <= 1'b0;
    end else if (cmd_i.capture) begin
      neg_q <= int_i[INT_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      a_q   <= a_i;
      b_q   <= b_i;
      p_q   <= RES_BITS'(1);
      mag_q <= int_i[INT_BITS-1] ? (~int_i + INT_BITS'(1)) : int_i;
      if (cmd_i.kind == K_INV) begin
        e_q <= {mod_i - MOD_MIN, {EPAD{1'b0}}};
      end else begin
        e_q <= exp_i;
      end
    end
    if (cmd_i.start) begin
      sh_q  <= sh_d;
      mc_q  <= mc_d;
      acc_q <= '0;
    end
    if (cmd_i.step) begin
      acc_q <= acc_d;
      sh_q  <= {sh_q[INT_BITS-2:0], 1'b0};
    end
    if (cmd_i.wb) begin
      case (cmd_i.ph)
        PH_RA:   a_q <= acc_q;
        PH_RB:   b_q <= acc_q;
        PH_CONV: p_q <= conv_r;
        PH_MUL:  p_q <= acc_q;
        PH_SQ:   p_q <= acc_q;
        PH_ML: begin
          if (e_q[EXP_BITS-1]) p_q <= acc_q;
          e_q <= {e_q[EXP_BITS-2:0], 1'b0};
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    s  = {1'b0, a_q} + {1'b0, b_q};
    s2 = (a_q >= b_q) ? {1'b0, a_q - b_q} : {1'b0, a_q} + {1'b0, mod_i} - {1'b0, b_q};
    case (cmd_i.kind)
      K_CONV, K_MUL, K_POW: res_o = p_q;
      K_ADD: res_o = (s >= {1'b0, mod_i}) ? RES_BITS'(s - {1'b0, mod_i}) : s[RES_BITS-1:0];
      K_SUB: res_o = s2[RES_BITS-1:0];
      K_INV: res_o = (a_q == '0) ? '0 : p_q;
      default: res_o = '0;
    endcase
  end

  assign lt_o = a_q < b_q;
  assign eq_o = a_q == b_q;

endmodule

// ----- design/dmra_ctrl.sv -----
`timescale 1ns / 1ps
module dmra_ctrl import dmra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] kind_i,
  input  logic       out_free_i,
  output logic       in_ready_o,
  output logic       out_load_o,
  output lane_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_WB    = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]          state_q, state_d, ph_q, ph_d, kind_q;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [IT_BITS-1:0]  it_q, it_d;

  assign in_ready_o = state_q == S_IDLE;
  assign out_load_o = state_q == S_FIN && out_free_i;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    it_d    = it_q;
    cmd_o   = '0;
    cmd_o.ph   = ph_q;
    cmd_o.kind = (state_q == S_IDLE) ? kind_i : kind_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          ph_d    = PH_RA;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        cnt_d   = (ph_q == PH_CONV) ? CNT_BITS'(INT_BITS - 1) : CNT_BITS'(RES_BITS - 1);
        state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) state_d = S_WB;
        else cnt_d = cnt_q - 1'b1;
      end
      S_WB: begin
        cmd_o.wb = 1'b1;
        state_d  = S_START;
        case (ph_q)
          PH_RA: ph_d = PH_RB;
          PH_RB: begin
            case (kind_q)
              K_CONV: ph_d = PH_CONV;
              K_MUL:  ph_d = PH_MUL;
              K_POW: begin
                ph_d = PH_SQ;
                it_d = IT_BITS'(EXP_BITS - 1);
              end
              K_INV: begin
                ph_d = PH_SQ;
                it_d = IT_BITS'(RES_BITS - 1);
              end
              default: state_d = S_FIN;
            endcase
          end
          PH_SQ: ph_d = PH_ML;
          PH_ML: begin
            if (it_q == '0) state_d = S_FIN;
            else begin
              it_d = it_q - 1'b1;
              ph_d = PH_SQ;
            end
          end
          default: state_d = S_FIN;
        endcase
      end
      S_FIN: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_RA;
      cnt_q   <= '0;
      it_q    <= '0;
      kind_q  <= K_CONV;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      cnt_q   <= cnt_d;
      it_q    <= it_d;
      if (state_q == S_IDLE && in_valid_i) kind_q <= kind_i;
    end
  end

endmodule

// ----- design/dual_modulus_residue_alu_core.sv -----
`timescale 1ns / 1ps
// Each item runs as phases: add/sub/compare take two operand reductions plus a finish
// state; mul adds a multiply, convert an integer reduction, inverse 30 square-and-multiply
// rounds, and power 63 rounds.
// One item at a time: the next transfer is accepted in the cycle after the result loads.
// Each lane works through a bit-serial modular multiplier. The result register frees input.
// Reset (async, active low) clears control and restores the default moduli.
module dual_modulus_residue_alu_core import dmra_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          kind_i,
  input  logic [RES_BITS-1:0] a_res0_i,
  input  logic [RES_BITS-1:0] a_res1_i,
  input  logic [RES_BITS-1:0] b_res0_i,
  input  logic [RES_BITS-1:0] b_res1_i,
  input  logic [INT_BITS-1:0] int_value_i,
  input  logic [EXP_BITS-1:0] exponent_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RES_BITS-1:0] res0_o,
  output logic [RES_BITS-1:0] res1_o,
  output logic                flag_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [RES_BITS-1:0] mod0_q, mod1_q, m0, m1, r0, r1;
  logic                lt0, lt1, eq0, eq1, out_load, flag_d;
  logic [RES_BITS-1:0] res0_q, res1_q;
  logic                flag_q, out_valid_q;
  lane_cmd_t           cmd;

  assign pready = 1'b1;
  assign prdata = {{(32-RES_BITS){1'b0}}, (paddr[2] == REG_MOD0) ? mod0_q : mod1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod0_q <= MOD0_RESET;
      mod1_q <= MOD1_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MOD0) mod0_q <= pwdata[RES_BITS-1:0];
      else mod1_q <= pwdata[RES_BITS-1:0];
    end
  end

  assign m0 = (mod0_q < MOD_MIN) ? MOD_MIN : mod0_q;
  assign m1 = (mod1_q < MOD_MIN) ? MOD_MIN : mod1_q;

  dmra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .out_free_i (!out_valid_q || out_ready_i),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  dmra_lane u_lane0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mod_i  (m0),
    .a_i    (a_res0_i),
    .b_i    (b_res0_i),
    .int_i  (int_value_i),
    .exp_i  (exponent_i),
    .res_o  (r0),
    .lt_o   (lt0),
    .eq_o   (eq0)
  );

  dmra_lane u_lane1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mod_i  (m1),
    .a_i    (a_res1_i),
    .b_i    (b_res1_i),
    .int_i  (int_value_i),
    .exp_i  (exponent_i),
    .res_o  (r1),
    .lt_o   (lt1),
    .eq_o   (eq1)
  );

  // lane 0 decides the ordering unless it ties
  always_comb begin
    case (cmd.kind)
      K_LT:    flag_d = eq0 ? lt1 : lt0;
      K_EQ:    flag_d = eq0 && eq1;
      default: flag_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res0_q <= r0;
      res1_q <= r1;
      flag_q <= flag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res0_o      = res0_q;
  assign res1_o      = res1_q;
  assign flag_o      = flag_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_flag_zero_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && flag_o |-> res0_o == '0 && res1_o == '0)
    else $error("comparison result carries residues");

endmodule

// ----- bench/dual_modulus_residue_alu_core_test.sv -----
`timescale 1ns / 1ps
module dual_modulus_residue_alu_core_test;
  import dmra_pkg::*;

  localparam logic [2:0] ADDR_MOD0 = 3'd0;
  localparam logic [2:0] ADDR_MOD1 = 3'd4;
  // longer than two of the slowest items, so the block surely backs up
  localparam int HOLD_CYCLES = 10000;

  typedef struct {
    logic [2:0]          kind;
    logic [RES_BITS-1:0] a0, a1, b0, b1;
    logic [INT_BITS-1:0] ival;
    logic [EXP_BITS-1:0] expo;
  } alu_op_t;

  typedef struct {
    logic [RES_BITS-1:0] r0, r1;
    logic                flag;
  } alu_res_t;

  class residue_scoreboard;
    longint unsigned modulus[2];
    alu_res_t        pending_q[$];
    int              mismatches;
    int              results_seen;

    function new();
      modulus[0] = 64'(MOD0_RESET);
      modulus[1] = 64'(MOD1_RESET);
      mismatches = 0;
      results_seen = 0;
    endfunction

    function longint unsigned lane_mod(int lane);
      return (modulus[lane] < 2) ? 64'd2 : modulus[lane];
    endfunction

    function longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                      longint unsigned m);
      longint unsigned acc;
      acc = 1 % m;
      for (int i = EXP_BITS - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * base) % m;
      end
      return acc;
    endfunction

    function longint unsigned to_residue(logic [63:0] raw, longint unsigned m);
      longint unsigned mag;
      if (!raw[63]) return raw % m;
      mag = (~raw + 64'd1) % m;
      return (mag == 0) ? 64'd0 : m - mag;
    endfunction

    // predicts the result of one transfer and queues it
    function void note_op(alu_op_t op);
      longint unsigned a[2], b[2], r[2], m;
      alu_res_t exp_res;
      bit decided;
      a[0] = 64'(op.a0); a[1] = 64'(op.a1); b[0] = 64'(op.b0); b[1] = 64'(op.b1);
      for (int i = 0; i < 2; i++) begin
        m = lane_mod(i);
        a[i] = a[i] % m;
        b[i] = b[i] % m;
        case (op.kind)
          K_CONV: r[i] = to_residue(op.ival, m);
          K_ADD:  r[i] = (a[i] + b[i]) % m;
          K_SUB:  r[i] = (a[i] + m - b[i]) % m;
          K_MUL:  r[i] = (a[i] * b[i]) % m;
          K_POW:  r[i] = pow_mod(a[i], 64'(op.expo), m);
          K_INV:  r[i] = (a[i] == 0) ? 64'd0 : pow_mod(a[i], m - 2, m);
          default: r[i] = 0;
        endcase
      end
      exp_res.r0 = r[0][RES_BITS-1:0];
      exp_res.r1 = r[1][RES_BITS-1:0];
      exp_res.flag = 1'b0;
      if (op.kind == K_LT) begin
        decided = 0;
        for (int i = 0; i < 2; i++)
          if (!decided && a[i] != b[i]) begin
            exp_res.flag = a[i] < b[i];
            decided = 1;
          end
      end else if (op.kind == K_EQ) begin
        exp_res.flag = (a[0] == b[0]) && (a[1] == b[1]);
      end
      pending_q.push_back(exp_res);
    endfunction

    function void check_result(alu_res_t got);
      alu_res_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result r0=%0d r1=%0d flag=%0b",
                                       got.r0, got.r1, got.flag);
        return;
      end
      want = pending_q.pop_front();
      if (want.r0 !== got.r0 || want.r1 !== got.r1 || want.flag !== got.flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch #%0d: expected r0=%0d r1=%0d flag=%0b, got r0=%0d r1=%0d flag=%0b",
                   results_seen, want.r0, want.r1, want.flag, got.r0, got.r1, got.flag);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [2:0]          kind_i = K_CONV;
  logic [RES_BITS-1:0] a_res0_i = '0, a_res1_i = '0, b_res0_i = '0, b_res1_i = '0;
  logic [INT_BITS-1:0] int_value_i = '0;
  logic [EXP_BITS-1:0] exponent_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [RES_BITS-1:0] res0_o, res1_o;
  logic                flag_o;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  dual_modulus_residue_alu_core dut (.*);

  residue_scoreboard sb = new();
  bit hold_request = 0;
  int ops_sent = 0;
  int kind_count[8];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #800_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    alu_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.r0 = res0_o;
      got.r1 = res1_o;
      got.flag = flag_o;
      sb.check_result(got);
    end
  end

  // receiver: stretches of differing stall density, plus one long hold-off on request
  initial begin
    int stall_pct;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 0;
      end else begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        repeat ($urandom_range(60, 10)) begin
          out_ready_i <= ($urandom_range(99) >= stall_pct);
          @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_op(alu_op_t op);
    in_valid_i  <= 1'b1;
    kind_i      <= op.kind;
    a_res0_i    <= op.a0;
    a_res1_i    <= op.a1;
    b_res0_i    <= op.b0;
    b_res1_i    <= op.b1;
    int_value_i <= op.ival;
    exponent_i  <= op.expo;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_op(op);
    kind_count[op.kind]++;
    ops_sent++;
  endtask

  task automatic idle_gap(int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    idle_gap(1);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.modulus[addr == ADDR_MOD1] = 64'(data[RES_BITS-1:0]);
  endtask

  function automatic alu_op_t make_op(logic [2:0] k, longint unsigned a0, longint unsigned a1,
                                      longint unsigned b0, longint unsigned b1,
                                      logic [63:0] iv, logic [62:0] e);
    alu_op_t op;
    op.kind = k;
    op.a0 = RES_BITS'(a0); op.a1 = RES_BITS'(a1);
    op.b0 = RES_BITS'(b0); op.b1 = RES_BITS'(b1);
    op.ival = iv; op.expo = e;
    return op;
  endfunction

  function automatic logic [RES_BITS-1:0] rand_residue(int lane);
    case ($urandom_range(5))
      0: return '1;
      1: return '0;
      2: return RES_BITS'($urandom);
      default: return RES_BITS'($urandom_range(32'(sb.lane_mod(lane) - 1)));
    endcase
  endfunction

  function automatic alu_op_t rand_op();
    alu_op_t op;
    int pick;
    pick = $urandom_range(99);
    // power and inverse are the slowest kinds, so keep them rare
    if (pick < 7)       op.kind = K_POW;
    else if (pick < 12) op.kind = K_INV;
    else                op.kind = 3'($urandom_range(7));
    if ((op.kind == K_POW || op.kind == K_INV) && pick >= 3 && $urandom_range(1))
      op.kind = K_MUL;
    op.a0 = rand_residue(0);
    op.a1 = rand_residue(1);
    if ((op.kind == K_LT || op.kind == K_EQ) && $urandom_range(2) == 0) begin
      op.b0 = op.a0;
      op.b1 = $urandom_range(1) ? op.a1 : rand_residue(1);
    end else begin
      op.b0 = rand_residue(0);
      op.b1 = rand_residue(1);
    end
    op.ival = {$urandom, $urandom};
    if ($urandom_range(3) == 0) op.ival = 64'($signed($urandom_range(2000)) - 1000);
    op.expo = EXP_BITS'({$urandom, $urandom});
    if ($urandom_range(2) == 0) op.expo = EXP_BITS'($urandom_range(20));
    return op;
  endfunction

  task automatic random_phase(int count, bit with_hold);
    int left;
    left = count;
    while (left > 0) begin
      repeat ($urandom_range(20, 1)) begin
        if (left > 0) begin
          send_op(rand_op());
          left--;
          if (with_hold && left == count - 5) hold_request = 1;
        end
      end
      if ($urandom_range(3) != 0) idle_gap($urandom_range(6, 1));
    end
  endtask

  initial begin
    logic [31:0] mod_set[8][2];
    logic [63:0] neg_min;
    neg_min = 64'h8000_0000_0000_0000;
    mod_set = '{'{32'd2, 32'd3}, '{32'h3FFF_FFFF, 32'h3FFF_FFFD},
                '{32'd0, 32'd1}, '{32'd65521, 32'd1000000007},
                '{32'hC000_0007, 32'd97}, '{32'd1000000009, 32'd536870909},
                '{32'd15, 32'd2}, '{32'd998244353, 32'd1000000009}};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed set at the reset moduli
    send_op(make_op(K_CONV, 0, 0, 0, 0, 64'd0, 0));
    send_op(make_op(K_CONV, 0, 0, 0, 0, 64'h7FFF_FFFF_FFFF_FFFF, 0));
    send_op(make_op(K_CONV, 0, 0, 0, 0, neg_min, 0));
    send_op(make_op(K_CONV, 0, 0, 0, 0, '1, 0));
    send_op(make_op(K_CONV, 0, 0, 0, 0, -64'sd1000000012, 0));
    send_op(make_op(K_CONV, 0, 0, 0, 0, -64'sd1000000007, 0));
    send_op(make_op(K_ADD, '1, '1, '1, '1, 0, 0));
    send_op(make_op(K_ADD, 1000000006, 1000000008, 1, 1, 0, 0));
    send_op(make_op(K_SUB, 0, 0, '1, '1, 0, 0));
    send_op(make_op(K_SUB, 5, 5, 3, 9, 0, 0));
    send_op(make_op(K_MUL, '1, '1, '1, '1, 0, 0));
    send_op(make_op(K_MUL, 1000000006, 1000000008, 1000000006, 1000000008, 0, 0));
    send_op(make_op(K_POW, 12345, 678, 0, 0, 0, 0));
    send_op(make_op(K_POW, 0, 0, 0, 0, 0, 0));
    send_op(make_op(K_POW, '1, '1, '1, '1, '1, '1));
    send_op(make_op(K_POW, 2, 3, 0, 0, '0, 63'd10));
    send_op(make_op(K_INV, 0, 1000000009, 0, 0, 0, 0));
    send_op(make_op(K_INV, 2, '1, 0, 0, 0, 0));
    send_op(make_op(K_LT, 7, 3, 7, 9, 0, 0));
    send_op(make_op(K_LT, 8, 3, 7, 9, 0, 0));
    send_op(make_op(K_LT, 7, 9, 7, 9, 0, 0));
    send_op(make_op(K_LT, 1000000008, 0, 2, 0, 0, 0));
    send_op(make_op(K_EQ, 5, 6, 5, 6, 0, 0));
    send_op(make_op(K_EQ, 1000000012, 6, 5, 1000000015, 0, 0));
    send_op(make_op(K_EQ, 5, 6, 5, 7, 0, 0));
    random_phase(150, 1);
    drain();

    foreach (mod_set[s]) begin
      apb_write(ADDR_MOD0, mod_set[s][0]);
      apb_write(ADDR_MOD1, mod_set[s][1]);
      @(posedge clk_i);
      random_phase(155, 0);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("covered %0d transfers over 9 modulus settings (conv %0d add %0d sub %0d mul %0d",
             ops_sent, kind_count[K_CONV], kind_count[K_ADD], kind_count[K_SUB],
             kind_count[K_MUL]);
    $display("  pow %0d inv %0d lt %0d eq %0d), %0d results checked",
             kind_count[K_POW], kind_count[K_INV], kind_count[K_LT], kind_count[K_EQ],
             sb.results_seen);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
